// ===== sv/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the pinhole point projection
// Result codes, register indexes, fixed-point widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;

    localparam int COORD_W = 32;   // Q16.16 point coordinate
    localparam int COEF_W  = 32;   // Q18.14 matrix coefficient
    localparam int PROD_W  = 64;   // exact coordinate x coefficient product
    localparam int CTERM_W = 48;   // coefficient x 1.0 (shift by 16)
    localparam int SUM_W   = 67;   // exact sum of four terms at 2^-30 scale
    localparam int LIM_W   = 13;   // image width / height register
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;

    // 0.001 at scale 2^-30
    localparam logic [SUM_W-1:0] DEPTH_MIN = SUM_W'(1073742);

    localparam logic [LIM_W-1:0] WIDTH_RST  = LIM_W'(640);
    localparam logic [LIM_W-1:0] HEIGHT_RST = LIM_W'(480);

    typedef enum logic [1:0] {
        OUT_INSIDE    = 2'd0,
        OUT_NONFINITE = 2'd1,
        OUT_NEAR      = 2'd2,
        OUT_OUTSIDE   = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_C01 = 4'd0,
        CFG_ROW0_C23 = 4'd1,
        CFG_ROW1_C01 = 4'd2,
        CFG_ROW1_C23 = 4'd3,
        CFG_ROW2_C01 = 4'd4,
        CFG_ROW2_C23 = 4'd5,
        CFG_WIDTH    = 4'd6,
        CFG_HEIGHT   = 4'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== sv/pinhole_point_projection.sv =====
// ----------------------------------------------------------------------------
// pinhole_point_projection: 3x4 matrix projection of 3D points to pixels
// Exact wide dot products, depth test, pipelined restoring division for u, v.
// ----------------------------------------------------------------------------
// Path from start to o_valid: input capture, products, row sums, depth test,
// overflow stage, division steps, result. Throughput: one point per cycle;
// busy stays low, the receiver cannot stall. One quotient bit per stage.
// Reset (synchronous, active low) clears the pipeline valid bits and loads
// the registers: matrix to zero, width 640, height 480.
`default_nettype none

module pinhole_point_projection #(
    parameter int MAX_DIMENSION = ppp_pkg::MAX_DIMENSION_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  signed [ppp_pkg::COORD_W-1:0] i_point_x,
    input  wire  signed [ppp_pkg::COORD_W-1:0] i_point_y,
    input  wire  signed [ppp_pkg::COORD_W-1:0] i_point_z,
    input  wire                              i_coords_finite,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ppp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [ppp_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_valid,
    output logic [$clog2(MAX_DIMENSION)-1:0] o_pixel_u,
    output logic [$clog2(MAX_DIMENSION)-1:0] o_pixel_v,
    output logic [1:0]                       o_outcome
);
    import ppp_pkg::*;

    localparam int QW   = $clog2(MAX_DIMENSION);
    localparam int DW   = SUM_W + QW;
    localparam int LIMW = (LIM_W > QW + 1) ? LIM_W : QW + 1;
    localparam int LAT  = 6 + QW;
    localparam logic [LIMW-1:0] MAX_LIM = LIMW'(MAX_DIMENSION);

    // ---------------- configuration ----------------
    logic signed [COEF_W-1:0] r_coef [0:11];   // row*4 + column
    logic [LIM_W-1:0]         r_lim_w;
    logic [LIM_W-1:0]         r_lim_h;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 12; k++) r_coef[k] <= '0;
            r_lim_w <= WIDTH_RST;
            r_lim_h <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROW0_C01: begin
                    r_coef[0] <= i_cfg_data[31:0];
                    r_coef[1] <= i_cfg_data[63:32];
                end
                CFG_ROW0_C23: begin
                    r_coef[2] <= i_cfg_data[31:0];
                    r_coef[3] <= i_cfg_data[63:32];
                end
                CFG_ROW1_C01: begin
                    r_coef[4] <= i_cfg_data[31:0];
                    r_coef[5] <= i_cfg_data[63:32];
                end
                CFG_ROW1_C23: begin
                    r_coef[6] <= i_cfg_data[31:0];
                    r_coef[7] <= i_cfg_data[63:32];
                end
                CFG_ROW2_C01: begin
                    r_coef[8] <= i_cfg_data[31:0];
                    r_coef[9] <= i_cfg_data[63:32];
                end
                CFG_ROW2_C23: begin
                    r_coef[10] <= i_cfg_data[31:0];
                    r_coef[11] <= i_cfg_data[63:32];
                end
                CFG_WIDTH:  r_lim_w <= i_cfg_data[LIM_W-1:0];
                CFG_HEIGHT: r_lim_h <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: input capture ----------------
    logic                     r_v1;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic                     r_fin1;

    // ---------------- stage 2: products ----------------
    logic                      r_v2, r_fin2;
    logic signed [PROD_W-1:0]  r_prod [0:2][0:2];
    logic signed [CTERM_W-1:0] r_cterm [0:2];

    // ---------------- stage 3: row sums ----------------
    logic                     r_v3, r_fin3;
    logic signed [SUM_W-1:0]  r_sum [0:2];

    // ---------------- stage 4: depth test, magnitudes ----------------
    logic             r_v4;
    t_outcome         r_code4;
    logic [DW-1:0]    r_mag_u4, r_mag_v4, r_den4;
    logic             r_neg_u4, r_neg_v4;

    // ---------------- divider pipeline, index 0 = overflow stage ----------------
    logic             r_dv    [0:QW];
    t_outcome         r_dcode [0:QW];
    logic [DW-1:0]    r_den   [0:QW];
    logic [DW-1:0]    r_rem_u [0:QW];
    logic [DW-1:0]    r_rem_v [0:QW];
    logic [QW-1:0]    r_q_u   [0:QW];
    logic [QW-1:0]    r_q_v   [0:QW];
    logic             r_neg_u [0:QW];
    logic             r_neg_v [0:QW];
    logic             r_ovf_u [0:QW];
    logic             r_ovf_v [0:QW];

    logic [DW-1:0]    n_rem_u [1:QW];
    logic [DW-1:0]    n_rem_v [1:QW];
    logic [QW-1:0]    n_q_u   [1:QW];
    logic [QW-1:0]    n_q_v   [1:QW];

    logic             n_depth_bad;
    logic [SUM_W-1:0] n_abs_a, n_abs_b;

    always_comb begin
        n_depth_bad = ($signed(r_sum[2]) <= $signed(DEPTH_MIN));
        n_abs_a = r_sum[0][SUM_W-1] ? SUM_W'(-r_sum[0]) : r_sum[0];
        n_abs_b = r_sum[1][SUM_W-1] ? SUM_W'(-r_sum[1]) : r_sum[1];
    end

    // one restoring step per stage; stage k decides quotient bit QW-1-k
    always_comb begin
        logic [DW-1:0] trial;
        for (int k = 0; k < QW; k++) begin
            trial = r_den[k] << (QW - 1 - k);
            if (r_rem_u[k] >= trial) begin
                n_rem_u[k+1] = r_rem_u[k] - trial;
                n_q_u[k+1]   = r_q_u[k] | (QW'(1) << (QW - 1 - k));
            end else begin
                n_rem_u[k+1] = r_rem_u[k];
                n_q_u[k+1]   = r_q_u[k];
            end
            if (r_rem_v[k] >= trial) begin
                n_rem_v[k+1] = r_rem_v[k] - trial;
                n_q_v[k+1]   = r_q_v[k] | (QW'(1) << (QW - 1 - k));
            end else begin
                n_rem_v[k+1] = r_rem_v[k];
                n_q_v[k+1]   = r_q_v[k];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int k = 0; k <= QW; k++) r_dv[k] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_dv[0] <= r_v4;
            for (int k = 0; k < QW; k++) r_dv[k+1] <= r_dv[k];
            o_valid <= r_dv[QW];
        end
    end

    // payload
    logic [LIMW-1:0] n_lim_w, n_lim_h;
    logic            n_ok_u, n_ok_v;

    always_comb begin
        n_lim_w = (LIMW'(r_lim_w) > MAX_LIM) ? MAX_LIM : LIMW'(r_lim_w);
        n_lim_h = (LIMW'(r_lim_h) > MAX_LIM) ? MAX_LIM : LIMW'(r_lim_h);
        // a negative numerator is inside only if it truncates to zero
        n_ok_u = !r_ovf_u[QW] && (LIMW'(r_q_u[QW]) < n_lim_w)
                 && (!r_neg_u[QW] || r_q_u[QW] == '0);
        n_ok_v = !r_ovf_v[QW] && (LIMW'(r_q_v[QW]) < n_lim_h)
                 && (!r_neg_v[QW] || r_q_v[QW] == '0);
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        r_x    <= i_point_x;
        r_y    <= i_point_y;
        r_z    <= i_point_z;
        r_fin1 <= i_coords_finite;
        // stage 2
        r_fin2 <= r_fin1;
        for (int r = 0; r < 3; r++) begin
            r_prod[r][0] <= r_coef[r*4]     * r_x;
            r_prod[r][1] <= r_coef[r*4 + 1] * r_y;
            r_prod[r][2] <= r_coef[r*4 + 2] * r_z;
            r_cterm[r]   <= {r_coef[r*4 + 3], 16'h0000};
        end
        // stage 3
        r_fin3 <= r_fin2;
        for (int r = 0; r < 3; r++) begin
            r_sum[r] <= SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                      + SUM_W'(r_prod[r][2]) + SUM_W'(r_cterm[r]);
        end
        // stage 4
        priority if (!r_fin3)    r_code4 <= OUT_NONFINITE;
        else if (n_depth_bad)    r_code4 <= OUT_NEAR;
        else                     r_code4 <= OUT_INSIDE;
        r_mag_u4 <= DW'(n_abs_a);
        r_mag_v4 <= DW'(n_abs_b);
        r_den4   <= DW'(r_sum[2]);
        r_neg_u4 <= r_sum[0][SUM_W-1];
        r_neg_v4 <= r_sum[1][SUM_W-1];
        // overflow stage: quotient would not fit below 2^QW
        r_dcode[0] <= r_code4;
        r_den[0]   <= r_den4;
        r_rem_u[0] <= r_mag_u4;
        r_rem_v[0] <= r_mag_v4;
        r_q_u[0]   <= '0;
        r_q_v[0]   <= '0;
        r_neg_u[0] <= r_neg_u4;
        r_neg_v[0] <= r_neg_v4;
        r_ovf_u[0] <= r_mag_u4 >= (r_den4 << QW);
        r_ovf_v[0] <= r_mag_v4 >= (r_den4 << QW);
        // division steps
        for (int k = 0; k < QW; k++) begin
            r_dcode[k+1] <= r_dcode[k];
            r_den[k+1]   <= r_den[k];
            r_rem_u[k+1] <= n_rem_u[k+1];
            r_rem_v[k+1] <= n_rem_v[k+1];
            r_q_u[k+1]   <= n_q_u[k+1];
            r_q_v[k+1]   <= n_q_v[k+1];
            r_neg_u[k+1] <= r_neg_u[k];
            r_neg_v[k+1] <= r_neg_v[k];
            r_ovf_u[k+1] <= r_ovf_u[k];
            r_ovf_v[k+1] <= r_ovf_v[k];
        end
        // result
        if (r_dcode[QW] != OUT_INSIDE) begin
            o_outcome <= r_dcode[QW];
            o_pixel_u <= '0;
            o_pixel_v <= '0;
        end else if (n_ok_u && n_ok_v) begin
            o_outcome <= OUT_INSIDE;
            o_pixel_u <= r_neg_u[QW] ? '0 : r_q_u[QW];
            o_pixel_v <= r_neg_v[QW] ? '0 : r_q_v[QW];
        end else begin
            o_outcome <= OUT_OUTSIDE;
            o_pixel_u <= '0;
            o_pixel_v <= '0;
        end
    end

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[0] |-> ##(QW + 1) o_valid)
        else $error("transaction lost in divider");

    a_inside_u: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome == OUT_INSIDE) |-> (LIMW'(o_pixel_u) < n_lim_w))
        else $error("column beyond frame");

    a_inside_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome == OUT_INSIDE) |-> (LIMW'(o_pixel_v) < n_lim_h))
        else $error("row beyond frame");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome != OUT_INSIDE) |-> (o_pixel_u == '0 && o_pixel_v == '0))
        else $error("rejected point carries a pixel");

endmodule

`default_nettype wire
